### src/fbc_pkg.sv
`default_nettype none
package fbc_pkg;

  localparam int PLANE_COUNT_DEF = 6;
  localparam int COORD_WIDTH_DEF = 32;

  localparam int FIELD_W   = 32;
  localparam int IDX_W     = 3;
  localparam int MASK_BITS = 6;
  localparam int FRAC_BITS = 16;

  localparam logic       MODE_LOAD = 1'b0;
  localparam logic       MODE_CULL = 1'b1;

  localparam logic [1:0] VERDICT_OUTSIDE   = 2'd0;
  localparam logic [1:0] VERDICT_INSIDE    = 2'd1;
  localparam logic [1:0] VERDICT_INTERSECT = 2'd2;

  typedef struct packed {
    logic                        mode;
    logic [IDX_W-1:0]            plane_index;
    logic signed [FIELD_W-1:0]   val_x;
    logic signed [FIELD_W-1:0]   val_y;
    logic signed [FIELD_W-1:0]   val_z;
    logic signed [FIELD_W-1:0]   val_w;
    logic signed [FIELD_W-1:0]   box_max_x;
    logic signed [FIELD_W-1:0]   box_max_y;
    logic signed [FIELD_W-1:0]   box_max_z;
    logic [MASK_BITS-1:0]        plane_mask;
  } in_item_t;

  typedef struct packed {
    logic [1:0]           verdict;
    logic [MASK_BITS-1:0] straddle_mask;
    logic [IDX_W-1:0]     next_start;
  } out_item_t;

  // sequencer to distance unit
  typedef struct packed {
    logic mul_en;
    logic add_en;
  } fbc_step_t;

  // distance unit back to sequencer
  typedef struct packed {
    logic pos_below;
    logic neg_below;
  } fbc_sign_t;

endpackage
`default_nettype wire

### src/frustum_box_cull.sv
`default_nettype none
// Frustum / box culler. A load item (mode 0) writes one plane (normal, offset d, Q16.16)
// into slot plane_index and gives no result; a slot at or beyond PLANE_COUNT is
// dropped. A cull item (mode 1) tests the box against every masked plane, start plane first,
// then ascending, and gives one result: verdict, straddle mask and the next start plane.
// Culls are handled one at a time. Each cull runs a plane scan of PLANE_COUNT + 1 passes
// (the plane store is read in the pass of a tested plane); every plane actually tested
// then goes through multiply, partial sums and sign decision. When no plane rejects the
// box a closing pass ends the scan; the result is then handed to the output register, a
// step that stretches while the previous result is still held there. The block then
// returns to idle and takes the next item; an early rejection cuts the scan short.
// The plane store is a one-port-read memory with registered read, so each tested plane costs
// a read turnaround; the multiply stage computes both corner distances at once.
// Results sit in an output register, so a new item is taken while the last result waits.
module frustum_box_cull #(
  parameter int PLANE_COUNT = fbc_pkg::PLANE_COUNT_DEF,
  parameter int COORD_WIDTH = fbc_pkg::COORD_WIDTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire fbc_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output fbc_pkg::out_item_t      out_data
);

  localparam int ADDR_W = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1;
  localparam int PASS_W = $clog2(PLANE_COUNT + 2);
  localparam int WORD_W = 4 * COORD_WIDTH + 3;
  localparam int IDX_W  = fbc_pkg::IDX_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PASS = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_ADD  = 3'd3;
  localparam logic [2:0] S_DEC  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0] state_r, state_nxt;

  // cull context
  logic [2:0][COORD_WIDTH-1:0]   box_min_r, box_max_r;
  logic [fbc_pkg::MASK_BITS-1:0] mask_r;
  logic [IDX_W-1:0]              start_r;
  logic [PASS_W-1:0]             pass_r, pass_nxt;
  logic [IDX_W-1:0]              plane_r;
  logic [1:0]                    verdict_r, verdict_nxt;
  logic [fbc_pkg::MASK_BITS-1:0] straddle_r, straddle_nxt;
  logic [IDX_W-1:0]              next_r, next_nxt;

  logic [PLANE_COUNT-1:0]        valid_r;
  fbc_pkg::out_item_t            out_r;
  logic                          out_valid_r;

  logic                          acc_in, acc_load, acc_cull;
  logic                          load_we;
  logic [WORD_W-1:0]             load_word, rd_word, plane_word;
  logic [ADDR_W-1:0]             rd_addr;
  logic                          rd_en;

  logic [PASS_W-1:0]             pass_m1;
  logic [IDX_W-1:0]              cand;
  logic [7:0]                    mask_wide;
  logic                          cand_tested, scan_done;

  fbc_pkg::fbc_step_t            step;
  fbc_pkg::fbc_sign_t            sign;
  logic [2:0][COORD_WIDTH-1:0]   normal;

  assign in_ready = (state_r == S_IDLE);
  assign acc_in   = in_valid && in_ready;
  assign acc_load = acc_in && (in_data.mode == fbc_pkg::MODE_LOAD);
  assign acc_cull = acc_in && (in_data.mode == fbc_pkg::MODE_CULL);

  // load path: keep low COORD_WIDTH bits, sign bits give the per-axis corner choice
  assign load_we   = acc_load && ({1'b0, in_data.plane_index} < 4'(PLANE_COUNT));
  assign load_word = {in_data.val_z[COORD_WIDTH-1], in_data.val_y[COORD_WIDTH-1],
                      in_data.val_x[COORD_WIDTH-1],
                      in_data.val_w[COORD_WIDTH-1:0], in_data.val_z[COORD_WIDTH-1:0],
                      in_data.val_y[COORD_WIDTH-1:0], in_data.val_x[COORD_WIDTH-1:0]};

  // scan order: pass 0 is the start plane, pass k>0 is plane k-1 unless it is the start
  assign pass_m1   = pass_r - 1'b1;
  assign cand      = (pass_r == '0) ? start_r : IDX_W'(pass_m1);
  assign mask_wide = {{(8 - fbc_pkg::MASK_BITS){1'b0}}, mask_r};
  assign scan_done = ({1'b0, pass_r} > (PASS_W + 1)'(PLANE_COUNT));
  assign cand_tested = !scan_done
                    && !((pass_r != '0) && (cand == start_r))
                    && ({1'b0, cand} < 4'(PLANE_COUNT))
                    && mask_wide[cand];

  assign rd_en   = (state_r == S_PASS) && cand_tested;
  assign rd_addr = cand[ADDR_W-1:0];

  fbc_ram #(
    .WIDTH (WORD_W),
    .DEPTH (PLANE_COUNT)
  ) u_planes (
    .clk   (clk),
    .we    (load_we),
    .waddr (in_data.plane_index[ADDR_W-1:0]),
    .wdata (load_word),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_word)
  );

  // a slot never loaded reads as the all-zero plane
  assign plane_word = valid_r[plane_r[ADDR_W-1:0]] ? rd_word : '0;
  assign normal = {plane_word[3*COORD_WIDTH-1:2*COORD_WIDTH],
                   plane_word[2*COORD_WIDTH-1:COORD_WIDTH],
                   plane_word[COORD_WIDTH-1:0]};

  assign step.mul_en = (state_r == S_MUL);
  assign step.add_en = (state_r == S_ADD);

  fbc_dist #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_dist (
    .clk      (clk),
    .step     (step),
    .normal   (normal),
    .offset   (plane_word[4*COORD_WIDTH-1:3*COORD_WIDTH]),
    .axis_neg (plane_word[WORD_W-1:4*COORD_WIDTH]),
    .box_min  (box_min_r),
    .box_max  (box_max_r),
    .sign     (sign)
  );

  always_comb begin
    state_nxt    = state_r;
    pass_nxt     = pass_r;
    verdict_nxt  = verdict_r;
    straddle_nxt = straddle_r;
    next_nxt     = next_r;
    case (state_r)
      S_IDLE: begin
        if (acc_cull) begin
          state_nxt    = S_PASS;
          pass_nxt     = '0;
          verdict_nxt  = fbc_pkg::VERDICT_INSIDE;
          straddle_nxt = '0;
          next_nxt     = in_data.plane_index;
        end
      end
      S_PASS: begin
        if (scan_done) begin
          state_nxt = S_FIN;
        end else if (cand_tested) begin
          state_nxt = S_MUL;
        end else begin
          pass_nxt = pass_r + 1'b1;
        end
      end
      S_MUL: state_nxt = S_ADD;
      S_ADD: state_nxt = S_DEC;
      S_DEC: begin
        if (sign.pos_below) begin
          verdict_nxt = fbc_pkg::VERDICT_OUTSIDE;
          next_nxt    = plane_r;
          state_nxt   = S_FIN;
        end else begin
          if (sign.neg_below) begin
            verdict_nxt = fbc_pkg::VERDICT_INTERSECT;
            straddle_nxt[plane_r] = 1'b1;
          end
          pass_nxt  = pass_r + 1'b1;
          state_nxt = S_PASS;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_we) begin
        valid_r[in_data.plane_index[ADDR_W-1:0]] <= 1'b1;
      end
      if ((state_r == S_FIN) && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pass_r     <= pass_nxt;
    verdict_r  <= verdict_nxt;
    straddle_r <= straddle_nxt;
    next_r     <= next_nxt;
    if (acc_cull) begin
      box_min_r <= {in_data.val_z[COORD_WIDTH-1:0], in_data.val_y[COORD_WIDTH-1:0],
                    in_data.val_x[COORD_WIDTH-1:0]};
      box_max_r <= {in_data.box_max_z[COORD_WIDTH-1:0], in_data.box_max_y[COORD_WIDTH-1:0],
                    in_data.box_max_x[COORD_WIDTH-1:0]};
      mask_r    <= in_data.plane_mask;
      start_r   <= in_data.plane_index;
    end
    if (rd_en) begin
      plane_r <= cand;
    end
    if ((state_r == S_FIN) && (!out_valid_r || out_ready)) begin
      out_r.verdict       <= verdict_r;
      out_r.straddle_mask <= straddle_r;
      out_r.next_start    <= next_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

### src/fbc_ram.sv
`default_nettype none
module fbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic                                  re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

### src/fbc_dist.sv
`default_nettype none
// Plane distance for both box corners: multiply, two partial sums, final sign.
module fbc_dist #(
  parameter int COORD_WIDTH = fbc_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                            clk,
  input  wire fbc_pkg::fbc_step_t              step,
  input  wire logic [2:0][COORD_WIDTH-1:0]     normal,
  input  wire logic [COORD_WIDTH-1:0]          offset,
  input  wire logic [2:0]                      axis_neg,
  input  wire logic [2:0][COORD_WIDTH-1:0]     box_min,
  input  wire logic [2:0][COORD_WIDTH-1:0]     box_max,
  output fbc_pkg::fbc_sign_t                   sign
);

  localparam int PROD_W = 2 * COORD_WIDTH;
  localparam int ACC_W  = PROD_W + 2;
  localparam int OFF_EXT = ACC_W - COORD_WIDTH - fbc_pkg::FRAC_BITS;

  logic [2:0][COORD_WIDTH-1:0] pos_c, neg_c;
  logic signed [PROD_W-1:0]    prod_pos_r [3];
  logic signed [PROD_W-1:0]    prod_neg_r [3];
  logic signed [ACC_W-1:0]     off_r;
  logic signed [ACC_W-1:0]     pos_a_r, pos_b_r, neg_a_r, neg_b_r;
  logic signed [ACC_W-1:0]     pos_sum, neg_sum;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      pos_c[a] = axis_neg[a] ? box_min[a] : box_max[a];
      neg_c[a] = axis_neg[a] ? box_max[a] : box_min[a];
    end
  end

  always_ff @(posedge clk) begin
    if (step.mul_en) begin
      for (int a = 0; a < 3; a++) begin
        prod_pos_r[a] <= $signed(normal[a]) * $signed(pos_c[a]);
        prod_neg_r[a] <= $signed(normal[a]) * $signed(neg_c[a]);
      end
      off_r <= {{OFF_EXT{offset[COORD_WIDTH-1]}}, offset, {fbc_pkg::FRAC_BITS{1'b0}}};
    end
    if (step.add_en) begin
      pos_a_r <= {{2{prod_pos_r[0][PROD_W-1]}}, prod_pos_r[0]}
               + {{2{prod_pos_r[1][PROD_W-1]}}, prod_pos_r[1]};
      pos_b_r <= {{2{prod_pos_r[2][PROD_W-1]}}, prod_pos_r[2]} + off_r;
      neg_a_r <= {{2{prod_neg_r[0][PROD_W-1]}}, prod_neg_r[0]}
               + {{2{prod_neg_r[1][PROD_W-1]}}, prod_neg_r[1]};
      neg_b_r <= {{2{prod_neg_r[2][PROD_W-1]}}, prod_neg_r[2]} + off_r;
    end
  end

  assign pos_sum = pos_a_r + pos_b_r;
  assign neg_sum = neg_a_r + neg_b_r;

  assign sign.pos_below = pos_sum[ACC_W-1];
  assign sign.neg_below = neg_sum[ACC_W-1];

endmodule
`default_nettype wire

### src/fbc_checker.sv
`default_nettype none
module fbc_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire fbc_pkg::in_item_t  in_data,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire fbc_pkg::out_item_t out_data
);

  // result held while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  a_inside_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.verdict == fbc_pkg::VERDICT_INSIDE) |-> out_data.straddle_mask == '0)
    else $error("inside verdict with straddle bits");

  a_intersect_bits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.verdict == fbc_pkg::VERDICT_INTERSECT)
      |-> out_data.straddle_mask != '0)
    else $error("intersect verdict without straddle bits");

  // a cull item keeps the block busy for at least the next cycle
  a_cull_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.mode == fbc_pkg::MODE_CULL) |=> !in_ready)
    else $error("new item taken straight after a cull");

endmodule

bind frustum_box_cull fbc_checker u_fbc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire

### bench/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          PLANES       = fbc_pkg::PLANE_COUNT_DEF;
  localparam int          ONE          = 1 << fbc_pkg::FRAC_BITS;   // 1.0 in Q16.16
  localparam int          MOST_NEG     = 32'sh8000_0000;
  localparam int          MOST_POS     = 32'sh7fff_ffff;
  localparam logic [5:0]  ALL_PLANES   = '1;
  localparam int          CYCLE_LIMIT  = 400000;
  // idle time after the last owed result is taken; leave a good margin
  localparam int          DRAIN_CYCLES = 60;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  fbc_pkg::in_item_t  in_data   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  fbc_pkg::out_item_t out_data;

  frustum_box_cull dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow plane store and verdict predictor
  // ---------------------------------------------------------------------------
  logic signed [fbc_pkg::FIELD_W-1:0] face_nx  [PLANES];
  logic signed [fbc_pkg::FIELD_W-1:0] face_ny  [PLANES];
  logic signed [fbc_pkg::FIELD_W-1:0] face_nz  [PLANES];
  logic signed [fbc_pkg::FIELD_W-1:0] face_d   [PLANES];
  logic [2:0]                         face_neg [PLANES];   // per-axis sign of the normal

  fbc_pkg::out_item_t pending_verdicts [$];   // verdicts still owed by the block, oldest first
  logic [2:0] coherent_start = '0;    // last predicted next_start, fed back as a start plane
  logic       steady_flow    = 1'b0;  // set: neither side idles

  int errors       = 0;
  int cycle_count  = 0;
  int loads_seen   = 0;
  int culls_seen   = 0;
  int verdict_tally [3] = '{0, 0, 0};

  function automatic logic signed [71:0] widen(input logic signed [fbc_pkg::FIELD_W-1:0] v);
    return {{(72 - fbc_pkg::FIELD_W){v[fbc_pkg::FIELD_W-1]}}, v};
  endfunction

  // Sign of plane p's distance to one corner of the box. The positive corner takes the
  // max on each axis where the normal is not negative; the negative corner the opposite.
  // Everything is held in 72 bits so the sum of the three Q32.32 products and the scaled
  // offset is exact; only the sign matters, and zero counts as not below.
  function automatic logic corner_outside(input int p, input fbc_pkg::in_item_t it,
                                          input logic pos_corner);
    logic signed [71:0] cx, cy, cz, dsum;
    cx = ((pos_corner ^ face_neg[p][0]) != 1'b0) ? widen(it.box_max_x) : widen(it.val_x);
    cy = ((pos_corner ^ face_neg[p][1]) != 1'b0) ? widen(it.box_max_y) : widen(it.val_y);
    cz = ((pos_corner ^ face_neg[p][2]) != 1'b0) ? widen(it.box_max_z) : widen(it.val_z);
    dsum = widen(face_nx[p]) * cx + widen(face_ny[p]) * cy + widen(face_nz[p]) * cz
         + (widen(face_d[p]) <<< fbc_pkg::FRAC_BITS);
    return dsum[71];
  endfunction

  // Start plane first (when in range), then the rest ascending; the first plane whose
  // positive corner is below rejects the box and stops the scan. Straddle bits gathered
  // before a rejection are kept.
  function automatic fbc_pkg::out_item_t cull_verdict_of(input fbc_pkg::in_item_t it);
    fbc_pkg::out_item_t r;
    int                 k, p;
    logic               settled;
    r.verdict       = fbc_pkg::VERDICT_INSIDE;
    r.straddle_mask = '0;
    r.next_start    = it.plane_index;
    settled         = 1'b0;
    for (k = 0; k <= PLANES; k++) begin
      p = (k == 0) ? int'(it.plane_index) : k - 1;
      if (!settled && (k == 0 || p != int'(it.plane_index)) && p < PLANES &&
          it.plane_mask[p]) begin
        if (corner_outside(p, it, 1'b1)) begin
          r.verdict    = fbc_pkg::VERDICT_OUTSIDE;
          r.next_start = 3'(p);
          settled      = 1'b1;
        end else if (corner_outside(p, it, 1'b0)) begin
          r.straddle_mask[p] = 1'b1;
          r.verdict          = fbc_pkg::VERDICT_INTERSECT;
        end
      end
    end
    return r;
  endfunction

  // Called once per accepted item, in acceptance order.
  function automatic void note_accepted(input fbc_pkg::in_item_t it);
    fbc_pkg::out_item_t r;
    if (it.mode == fbc_pkg::MODE_LOAD) begin
      loads_seen++;
      if (it.plane_index < PLANES) begin
        face_nx[it.plane_index]  = it.val_x;
        face_ny[it.plane_index]  = it.val_y;
        face_nz[it.plane_index]  = it.val_z;
        face_d[it.plane_index]   = it.val_w;
        face_neg[it.plane_index] = {it.val_z[fbc_pkg::FIELD_W-1], it.val_y[fbc_pkg::FIELD_W-1],
                                    it.val_x[fbc_pkg::FIELD_W-1]};
      end
    end else begin
      r = cull_verdict_of(it);
      pending_verdicts.push_back(r);
      coherent_start = r.next_start;
      culls_seen++;
      verdict_tally[r.verdict]++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure and the checker
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_ready <= steady_flow || ($urandom_range(0, 99) >= 30);
  end

  always @(posedge clk) begin : verdict_check
    fbc_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected result, none awaited: verdict %0d straddle %b next %0d",
                 $time, out_data.verdict, out_data.straddle_mask, out_data.next_start);
        errors++;
      end else begin
        want = pending_verdicts.pop_front();
        if (out_data.verdict !== want.verdict) begin
          $display("%0t: verdict expected %0d actual %0d", $time, want.verdict,
                   out_data.verdict);
          errors++;
        end
        if (out_data.straddle_mask !== want.straddle_mask) begin
          $display("%0t: straddle_mask expected %b actual %b", $time, want.straddle_mask,
                   out_data.straddle_mask);
          errors++;
        end
        if (out_data.next_start !== want.next_start) begin
          $display("%0t: next_start expected %0d actual %0d", $time, want.next_start,
                   out_data.next_start);
          errors++;
        end
      end
    end
  end

  // hard stop in case the block hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed", cycle_count,
               pending_verdicts.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------
  // Always entered at a rising edge. Valid is only dropped for a sender gap, so
  // back-to-back items keep it high without a low/high pair in one step.
  task automatic send_item(input fbc_pkg::in_item_t it);
    while (!steady_flow && $urandom_range(0, 99) < 30) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    note_accepted(it);
  endtask

  function automatic fbc_pkg::in_item_t mk_load(input logic [2:0] slot, input int nx,
                                                input int ny, input int nz, input int d);
    fbc_pkg::in_item_t it;
    it             = '0;
    it.mode        = fbc_pkg::MODE_LOAD;
    it.plane_index = slot;
    it.val_x       = nx;
    it.val_y       = ny;
    it.val_z       = nz;
    it.val_w       = d;
    return it;
  endfunction

  function automatic fbc_pkg::in_item_t mk_cull(input logic [2:0] start,
                                                input logic [5:0] mask,
                                                input int x0, input int y0, input int z0,
                                                input int x1, input int y1, input int z1);
    fbc_pkg::in_item_t it;
    it             = '0;
    it.mode        = fbc_pkg::MODE_CULL;
    it.plane_index = start;
    it.plane_mask  = mask;
    it.val_x       = x0;
    it.val_y       = y0;
    it.val_z       = z0;
    it.box_max_x   = x1;
    it.box_max_y   = y1;
    it.box_max_z   = z1;
    return it;
  endfunction

  function automatic int span(input int lo, input int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  // normal component in [-1, 1], exactly zero now and then
  function automatic int axis_weight();
    return ($urandom_range(0, 9) == 0) ? 0 : span(-ONE, ONE);
  endfunction

  // Mostly well-formed traffic: sensible planes and boxes of a scene a few hundred units
  // across, so all three verdicts turn up. The remainder is raw noise over every field.
  function automatic fbc_pkg::in_item_t traffic_item();
    fbc_pkg::in_item_t it;
    int                roll, ctr, half;
    it.mode        = 1'($urandom_range(0, 1));
    it.plane_index = 3'($urandom);
    it.val_x       = $urandom;
    it.val_y       = $urandom;
    it.val_z       = $urandom;
    it.val_w       = $urandom;
    it.box_max_x   = $urandom;
    it.box_max_y   = $urandom;
    it.box_max_z   = $urandom;
    it.plane_mask  = 6'($urandom);
    roll = int'($urandom_range(0, 99));
    if (roll < 12) return it;
    if (roll < 30) begin
      // plane reload; box fields and mask stay as junk, the block ignores them
      it.mode        = fbc_pkg::MODE_LOAD;
      it.plane_index = 3'($urandom_range(0, PLANES - 1));
      it.val_x       = axis_weight();
      it.val_y       = axis_weight();
      it.val_z       = axis_weight();
      it.val_w       = span(-100 * ONE, 300 * ONE);
      return it;
    end
    it.mode = fbc_pkg::MODE_CULL;
    roll    = int'($urandom_range(0, 9));
    if (roll < 5 && coherent_start < PLANES) it.plane_index = coherent_start;
    else if (roll < 9)                       it.plane_index = 3'($urandom_range(0, PLANES - 1));
    else                                     it.plane_index = 3'($urandom_range(PLANES, 7));
    if ($urandom_range(0, 9) < 6) it.plane_mask = ALL_PLANES;
    ctr = span(-300 * ONE, 300 * ONE);
    half = span(0, 60 * ONE);
    it.val_x = ctr - half;
    it.box_max_x = ctr + half;
    ctr = span(-300 * ONE, 300 * ONE);
    half = span(0, 60 * ONE);
    it.val_y = ctr - half;
    it.box_max_y = ctr + half;
    ctr = span(-300 * ONE, 300 * ONE);
    half = span(0, 60 * ONE);
    it.val_z = ctr - half;
    it.box_max_z = ctr + half;
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic apply_reset();
    int k;
    for (k = 0; k < PLANES; k++) begin
      face_nx[k]  = '0;
      face_ny[k]  = '0;
      face_nz[k]  = '0;
      face_d[k]   = '0;
      face_neg[k] = '0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
  endtask

  // After reset every plane is zero, so every distance is exactly zero: never below.
  // Loads to slots past the last plane must leave the store untouched.
  task automatic test_reset_state();
    send_item(mk_cull(3'd0, ALL_PLANES, 0, 0, 0, 0, 0, 0));
    send_item(mk_load(3'd6, ONE, ONE, ONE, -ONE));
    send_item(mk_load(3'd7, -ONE, -ONE, -ONE, -ONE));
    send_item(mk_cull(3'd0, ALL_PLANES, ONE, ONE, ONE, 2 * ONE, 2 * ONE, 2 * ONE));
  endtask

  // Axis-aligned cube of half-size 10 as the frustum: one plane per face.
  task automatic test_cube_culls();
    localparam int H = 10 * ONE;
    send_item(mk_load(3'd0, ONE, 0, 0, H));
    send_item(mk_load(3'd1, -ONE, 0, 0, H));
    send_item(mk_load(3'd2, 0, ONE, 0, H));
    send_item(mk_load(3'd3, 0, -ONE, 0, H));
    send_item(mk_load(3'd4, 0, 0, ONE, H));
    send_item(mk_load(3'd5, 0, 0, -ONE, H));
    // well inside
    send_item(mk_cull(3'd0, ALL_PLANES, -ONE, -ONE, -ONE, ONE, ONE, ONE));
    // beyond +y: rejected by plane 3 part way through the scan
    send_item(mk_cull(3'd0, ALL_PLANES, -ONE, 12 * ONE, -ONE, ONE, 14 * ONE, ONE));
    // same box, rejected straight away by the start plane
    send_item(mk_cull(3'd3, ALL_PLANES, -ONE, 12 * ONE, -ONE, ONE, 14 * ONE, ONE));
    // across the -x face
    send_item(mk_cull(3'd0, ALL_PLANES, -12 * ONE, -ONE, -ONE, -8 * ONE, ONE, ONE));
    // positive corner exactly on the -x face: zero distance is not outside
    send_item(mk_cull(3'd0, ALL_PLANES, -14 * ONE, -ONE, -ONE, -10 * ONE, ONE, ONE));
    // negative corner exactly on the -x face: not a straddle
    send_item(mk_cull(3'd0, ALL_PLANES, -10 * ONE, -ONE, -ONE, 5 * ONE, ONE, ONE));
    // start plane out of range, box beyond +x
    send_item(mk_cull(3'd6, ALL_PLANES, 11 * ONE, -ONE, -ONE, 13 * ONE, ONE, ONE));
    // start plane out of range, inside: start echoed
    send_item(mk_cull(3'd7, ALL_PLANES, -ONE, -ONE, -ONE, ONE, ONE, ONE));
    // nothing tested at all
    send_item(mk_cull(3'd2, 6'b000000, 11 * ONE, -ONE, -ONE, 13 * ONE, ONE, ONE));
    // rejecting plane masked off
    send_item(mk_cull(3'd0, 6'b110111, -ONE, 12 * ONE, -ONE, ONE, 14 * ONE, ONE));
    // straddles -x, then rejected by +z: straddle bit survives the rejection
    send_item(mk_cull(3'd4, ALL_PLANES, -12 * ONE, -ONE, 12 * ONE, -8 * ONE, ONE, 14 * ONE));
  endtask

  // Full-scale coefficients and coordinates, including an inverted box.
  task automatic test_extreme_values();
    send_item(mk_load(3'd2, MOST_POS, MOST_NEG, MOST_NEG, MOST_POS));
    send_item(mk_cull(3'd2, 6'b000100, MOST_NEG, MOST_NEG, MOST_NEG,
                      MOST_POS, MOST_POS, MOST_POS));
    send_item(mk_cull(3'd5, ALL_PLANES, MOST_POS, MOST_POS, MOST_POS,
                      MOST_NEG, MOST_NEG, MOST_NEG));
  endtask

  task automatic test_random_traffic();
    int n;
    for (n = 0; n < 1600; n++) send_item(traffic_item());
  endtask

  // same traffic with both sides running flat out
  task automatic test_steady_stream();
    int n;
    steady_flow <= 1'b1;
    for (n = 0; n < 330; n++) send_item(traffic_item());
    steady_flow <= 1'b0;
  endtask

  initial begin
    apply_reset();
    test_reset_state();
    test_cube_culls();
    test_extreme_values();
    test_random_traffic();
    test_steady_stream();

    // all items are in; let the owed results drain, then a few idle cycles
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d plane loads and %0d box culls", loads_seen, culls_seen);
    $display("culls by verdict: outside %0d, inside %0d, intersecting %0d; %0d mismatches",
             verdict_tally[fbc_pkg::VERDICT_OUTSIDE], verdict_tally[fbc_pkg::VERDICT_INSIDE],
             verdict_tally[fbc_pkg::VERDICT_INTERSECT], errors);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
